FILE: rtl/core/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Types and constants shared by the text console cursor and scroll block.
// ----------------------------------------------------------------------------
package tccs_pkg;

   localparam int CMD_W       = 2;
   localparam int CHAR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int LEFT_W      = 3;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

   localparam logic [ATTR_W-1:0] RESET_COLOR = 8'h0C;
   localparam logic [LEFT_W-1:0] TAB_SPACES  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [CHAR_W-1:0]      char_code;
      logic [ROW_FIELD_W-1:0] read_row;
      logic [COL_FIELD_W-1:0] read_col;
   } req_item_type;

   typedef struct packed {
      logic [ROW_FIELD_W-1:0] cursor_row;
      logic [COL_FIELD_W-1:0] cursor_col;
      logic                   scrolled;
      logic [CELL_W-1:0]      cell_value;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_SCROLL,
      ST_CLEAR,
      ST_READ
   } state_type;

endpackage

FILE: rtl/core/text_console_cursor_scroll.sv
// return and a newline that does not scroll answer straight from idle; put writes the cell in
// ST_PUT, read returns the registered RAM output in ST_READ, a tab writes TAB_SPACES spaces,
// a scroll blanks the new bottom row and clear sweeps every cell; one item at a time
// the single cell RAM write port sets the pace of every write step; one row-address unit maps rows
// reset: synchronous; a clearing pass over all ROWS*COLUMNS cells fills the screen, busy meanwhile
// results are strobed for one cycle on rsp_valid
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text screen with cursor, wrap, scroll, clear and cell read, using a circular
// row map over one cell RAM and a small sequencer.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  tccs_pkg::req_item_type         req_data,
   output logic                           rsp_valid,
   output tccs_pkg::rsp_item_type         rsp_data,
   input  logic                           csr_we,
   input  logic [tccs_pkg::ATTR_W-1:0]    csr_wdata
);

   import tccs_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int RW         = $clog2(ROWS);
   localparam int CW         = $clog2(COLUMNS);
   localparam int AW         = $clog2(CELL_COUNT);

   state_type            state_ff, state_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        top_ff, top_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic [LEFT_W-1:0]    left_ff, left_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 scr_ff, scr_in;
   logic [ATTR_W-1:0]    color_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_ff, rsp_in;

   logic                 finish;
   logic [CELL_W-1:0]    cell_rd;
   logic [RW-1:0]        au_row;
   logic [CW-1:0]        au_col;
   logic [RW:0]          phys_sum;
   logic [RW:0]          phys_row;
   logic [AW-1:0]        au_addr;
   logic [RW-1:0]        top_next;
   logic                 col_last;
   logic                 row_last;
   logic                 read_ok;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [CELL_W-1:0]    mem_wdata;
   logic [CELL_W-1:0]    rd_data;

   // shared row-map address unit
   always_comb begin
      phys_sum = {1'b0, au_row} + {1'b0, top_ff};
      if (phys_sum >= (RW+1)'(ROWS)) begin
         phys_row = phys_sum - (RW+1)'(ROWS);
      end else begin
         phys_row = phys_sum;
      end
      au_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(au_col);
   end

   assign top_next = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign col_last = (col_ff == CW'(COLUMNS - 1));
   assign row_last = (row_ff == RW'(ROWS - 1));
   assign read_ok  = (32'(req_data.read_row) < ROWS) && (32'(req_data.read_col) < COLUMNS);

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (au_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      sweep_in  = sweep_ff;
      left_in   = left_ff;
      char_in   = char_ff;
      scr_in    = scr_ff;
      finish    = 1'b0;
      cell_rd   = '0;
      mem_we    = 1'b0;
      mem_waddr = au_addr;
      mem_wdata = {color_ff, CH_SPACE};
      au_row    = row_ff;
      au_col    = col_ff;

      case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = {RESET_COLOR, CH_SPACE};
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == AW'(CELL_COUNT - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            au_row = RW'(req_data.read_row);
            au_col = CW'(req_data.read_col);
            if (start) begin
               scr_in = 1'b0;
               case (req_data.cmd)
                  CMD_PUT: begin
                     if (req_data.char_code == CH_NEWLINE) begin
                        col_in = '0;
                        if (row_last) begin
                           scr_in   = 1'b1;
                           top_in   = top_next;
                           sweep_in = '0;
                           left_in  = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + 1'b1;
                           finish = 1'b1;
                        end
                     end else if (req_data.char_code == CH_RETURN) begin
                        col_in = '0;
                        finish = 1'b1;
                     end else if (req_data.char_code == CH_TAB) begin
                        left_in  = TAB_SPACES;
                        char_in  = CH_SPACE;
                        state_in = ST_PUT;
                     end else begin
                        left_in  = LEFT_W'(1);
                        char_in  = req_data.char_code;
                        state_in = ST_PUT;
                     end
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     top_in   = '0;
                     row_in   = '0;
                     col_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     if (read_ok) begin
                        state_in = ST_READ;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = {color_ff, char_ff};
            left_in   = left_ff - 1'b1;
            if (col_last) begin
               col_in = '0;
               if (!row_last) begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
            if (col_last && row_last) begin
               scr_in   = 1'b1;
               top_in   = top_next;
               sweep_in = '0;
               state_in = ST_SCROLL;
            end else if (left_ff == LEFT_W'(1)) begin
               finish = 1'b1;
            end
         end
         ST_SCROLL: begin
            au_row   = RW'(ROWS - 1);
            au_col   = sweep_ff[CW-1:0];
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff[CW-1:0] == CW'(COLUMNS - 1)) begin
               sweep_in = '0;
               if (left_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  state_in = ST_PUT;
               end
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == AW'(CELL_COUNT - 1)) begin
               sweep_in = '0;
               finish   = 1'b1;
            end
         end
         ST_READ: begin
            cell_rd = rd_data;
            finish  = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end

      rsp_in.cursor_row = ROW_FIELD_W'(row_in);
      rsp_in.cursor_col = COL_FIELD_W'(col_in);
      rsp_in.scrolled   = scr_in;
      rsp_in.cell_value = cell_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         left_ff      <= '0;
         scr_ff       <= 1'b0;
         color_ff     <= RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         left_ff      <= left_in;
         scr_ff       <= scr_in;
         rsp_valid_ff <= finish;
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // cursor and row map stay on the screen
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS))
      else $error("cursor outside the screen");

   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) < ROWS)
      else $error("top row pointer outside the screen");

   // an accepted item either finishes at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted item neither answered nor in progress");

   // leaving a work state always delivers a result
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && ($past(state_ff) != ST_INIT) |-> rsp_valid)
      else $error("work finished without a result strobe");

endmodule

FILE: rtl/core/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: verif/text_console_cursor_scroll_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the text console: a queue-fed driver sends put,
// clear, read and unused commands in bursts with gaps. An in-bench screen
// image with its own cursor and color predicts every response. A monitor
// checks each strobed response against the oldest prediction. The text
// color changes between phases, once the console has gone idle.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tccs_pkg::*;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int PHASE_ITEMS = 76;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_valid;
   rsp_item_type rsp_data;
   logic         csr_we = 1'b0;
   logic [ATTR_W-1:0] csr_wdata = '0;

   // screen image and cursor kept by the bench
   logic [CELL_W-1:0] shadow_screen [SCREEN_ROWS][SCREEN_COLS];
   int unsigned       shadow_row;
   int unsigned       shadow_col;
   logic [ATTR_W-1:0] shadow_color;

   req_item_type pending_items [$];
   rsp_item_type expected_results [$];

   bit took_item;
   int burst_left;
   int gap_left;
   int cycle_count;
   int items_sent;
   int results_checked;
   int mismatch_count;
   int scroll_results;
   int read_results;
   int color_writes;

   text_console_cursor_scroll #(
      .COLUMNS (SCREEN_COLS),
      .ROWS    (SCREEN_ROWS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void blank_screen();
      for (int r = 0; r < SCREEN_ROWS; r++)
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[r][c] = {shadow_color, CH_SPACE};
      shadow_row = 0;
      shadow_col = 0;
   endfunction

   function automatic bit next_line();
      shadow_row++;
      if (shadow_row >= SCREEN_ROWS) begin
         for (int r = 0; r < SCREEN_ROWS - 1; r++)
            for (int c = 0; c < SCREEN_COLS; c++)
               shadow_screen[r][c] = shadow_screen[r + 1][c];
         for (int c = 0; c < SCREEN_COLS; c++)
            shadow_screen[SCREEN_ROWS - 1][c] = {shadow_color, CH_SPACE};
         shadow_row = SCREEN_ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit write_char(logic [CHAR_W-1:0] ch);
      shadow_screen[shadow_row][shadow_col] = {shadow_color, ch};
      shadow_col++;
      if (shadow_col >= SCREEN_COLS) begin
         shadow_col = 0;
         return next_line();
      end
      return 1'b0;
   endfunction

   function automatic rsp_item_type console_response(req_item_type it);
      rsp_item_type r;
      bit rolled;
      r = '0;
      rolled = 1'b0;
      case (it.cmd)
         CMD_PUT: begin
            if (it.char_code == CH_NEWLINE) begin
               shadow_col = 0;
               rolled = next_line();
            end else if (it.char_code == CH_RETURN) begin
               shadow_col = 0;
            end else if (it.char_code == CH_TAB) begin
               for (int i = 0; i < TAB_SPACES; i++)
                  if (write_char(CH_SPACE))
                     rolled = 1'b1;
            end else begin
               rolled = write_char(it.char_code);
            end
         end
         CMD_CLEAR: begin
            blank_screen();
         end
         CMD_READ: begin
            if (it.read_row < SCREEN_ROWS && it.read_col < SCREEN_COLS)
               r.cell_value = shadow_screen[it.read_row][it.read_col];
         end
         default: ;
      endcase
      r.cursor_row = shadow_row[ROW_FIELD_W-1:0];
      r.cursor_col = shadow_col[COL_FIELD_W-1:0];
      r.scrolled   = rolled;
      return r;
   endfunction

   function automatic req_item_type console_item(logic [CMD_W-1:0] cmd,
                                                 logic [CHAR_W-1:0] ch,
                                                 logic [ROW_FIELD_W-1:0] row,
                                                 logic [COL_FIELD_W-1:0] col);
      req_item_type it;
      it.cmd       = cmd;
      it.char_code = ch;
      it.read_row  = row;
      it.read_col  = col;
      return it;
   endfunction

   task automatic queue_put(logic [CHAR_W-1:0] ch);
      pending_items.push_back(console_item(CMD_PUT, ch, 5'($urandom_range(0, 31)),
                                           7'($urandom_range(0, 127))));
   endtask

   task automatic queue_read(logic [ROW_FIELD_W-1:0] row, logic [COL_FIELD_W-1:0] col);
      pending_items.push_back(console_item(CMD_READ, 8'($urandom_range(0, 255)), row, col));
   endtask

   task automatic queue_clear();
      pending_items.push_back(console_item(CMD_CLEAR, 8'($urandom_range(0, 255)),
                                           5'($urandom_range(0, 31)),
                                           7'($urandom_range(0, 127))));
   endtask

   task automatic queue_directed();
      queue_read(5'd0, 7'd0);
      queue_read(5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1));
      queue_read(5'(SCREEN_ROWS), 7'd0);
      queue_read(5'd0, 7'(SCREEN_COLS));
      queue_read(5'd31, 7'd127);
      pending_items.push_back(console_item(CMD_SPARE, 8'h00, 5'd0, 7'd0));
      queue_put("A");
      queue_read(5'd0, 7'd0);
      queue_put(8'h00);
      queue_put(8'hFF);
      queue_put(CH_TAB);
      queue_read(5'd0, 7'd3);
      queue_read(5'd0, 7'd6);
      queue_put(CH_RETURN);
      queue_put(CH_NEWLINE);
      queue_put("Z");
      queue_read(5'd1, 7'd0);
      queue_clear();
      queue_read(5'd0, 7'd0);
      pending_items.push_back(console_item(CMD_SPARE, 8'hFF, 5'd31, 7'd127));
   endtask

   // mostly lines of text ending in newline or return, plus newline runs, reads, clears and noise
   task automatic queue_random_traffic(int count);
      int left;
      int pick;
      int run_len;
      left = count;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(0, 10);
            for (int k = 0; k < run_len && left > 0; k++) begin
               if ($urandom_range(0, 9) == 0)
                  queue_put(CH_TAB);
               else if ($urandom_range(0, 19) == 0)
                  queue_put(8'($urandom_range(0, 255)));
               else
                  queue_put(8'($urandom_range(8'h20, 8'h7E)));
               left--;
            end
            if (left > 0) begin
               queue_put(($urandom_range(0, 3) == 0) ? CH_RETURN : CH_NEWLINE);
               left--;
            end
         end else if (pick < 60) begin
            run_len = $urandom_range(1, 30);
            for (int k = 0; k < run_len && left > 0; k++) begin
               queue_put(CH_NEWLINE);
               left--;
            end
         end else if (pick < 78) begin
            queue_read(5'($urandom_range(0, SCREEN_ROWS - 1)),
                       7'($urandom_range(0, SCREEN_COLS - 1)));
            left--;
         end else if (pick < 82) begin
            queue_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
            left--;
         end else if (pick < 86) begin
            pending_items.push_back(console_item(CMD_SPARE, 8'($urandom_range(0, 255)),
                                                 5'($urandom_range(0, 31)),
                                                 7'($urandom_range(0, 127))));
            left--;
         end else if (pick < 88) begin
            queue_clear();
            left--;
         end else begin
            pending_items.push_back(console_item(2'($urandom_range(0, 3)),
                                                 8'($urandom_range(0, 255)),
                                                 5'($urandom_range(0, 31)),
                                                 7'($urandom_range(0, 127))));
            left--;
         end
      end
   endtask

   task automatic wait_console_idle();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || start || expected_results.size() != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_text_color(logic [ATTR_W-1:0] color);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= color;
      shadow_color = color;
      color_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // driver: bursts of items with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (start) begin
            burst_left--;
            if (burst_left <= 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                          ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (burst_left <= 0)
               burst_left = $urandom_range(1, 24);
            req_data <= pending_items.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      rsp_item_type want;
      cycle_count++;
      took_item = 1'b0;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_results.size());
         $display("text_console_cursor_scroll regression: fail");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response row %0d col %0d scr %0b cell %h",
                           rsp_data.cursor_row, rsp_data.cursor_col,
                           rsp_data.scrolled, rsp_data.cell_value);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (rsp_data.cursor_row !== want.cursor_row ||
                   rsp_data.cursor_col !== want.cursor_col ||
                   rsp_data.scrolled   !== want.scrolled   ||
                   rsp_data.cell_value !== want.cell_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch on response %0d: exp row %0d col %0d scr %0b cell %h,",
                              results_checked, want.cursor_row, want.cursor_col,
                              want.scrolled, want.cell_value);
                     $display("   got row %0d col %0d scr %0b cell %h",
                              rsp_data.cursor_row, rsp_data.cursor_col,
                              rsp_data.scrolled, rsp_data.cell_value);
                  end
               end
               if (want.scrolled)
                  scroll_results++;
               if (want.cell_value != 0)
                  read_results++;
            end
         end
         if (start && !busy) begin
            took_item = 1'b1;
            items_sent++;
            expected_results.push_back(console_response(req_data));
         end
      end
   end

   initial begin
      shadow_color = RESET_COLOR;
      blank_screen();
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);
      wait_console_idle();
      @(posedge clock);
      queue_directed();
      wait_console_idle();

      apply_text_color(8'h00);
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS);
      wait_console_idle();

      apply_text_color(8'hFF);
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS / 2);
      wait_console_idle();
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS / 2);
      wait_console_idle();

      apply_text_color(8'($urandom_range(0, 255)));
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS);
      wait_console_idle();

      apply_text_color(8'($urandom_range(0, 255)));
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS);
      wait_console_idle();

      apply_text_color(RESET_COLOR);
      @(posedge clock);
      queue_random_traffic(PHASE_ITEMS);
      wait_console_idle();

      repeat (20) @(posedge clock);
      $display("sent %0d items over %0d color settings, checked %0d responses",
               items_sent, color_writes, results_checked);
      $display("%0d responses scrolled, %0d reads returned a nonzero cell, %0d mismatches",
               scroll_results, read_results, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("text_console_cursor_scroll regression: pass");
      end else begin
         $display("%0d responses never arrived", expected_results.size());
         $display("text_console_cursor_scroll regression: fail");
      end
      $finish;
   end

endmodule
